>>> hw/rtl/mbe_pkg.sv
package mbe_pkg;

  // Fixed-point format of the input point and the iteration counter.
  localparam int IN_W      = 30;
  localparam int FRAC_BITS = 27;
  localparam int CNT_W     = 8;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(255);

  // Multiplier operand width. A z that has not escaped has |z| <= 2 and fits in
  // FRAC_BITS + 3 signed bits; the first round squares c itself.
  localparam int M_W    = (IN_W > FRAC_BITS + 3) ? IN_W : FRAC_BITS + 3;
  localparam int PROD_W = 2 * M_W;
  // Sums and differences of two products.
  localparam int W_W    = PROD_W + 1;
  // Width of a freshly updated z before the range check.
  localparam int ZN_W   = 2 * M_W - FRAC_BITS + 1;

  // Escape threshold |z|^2 > 4, scaled by 2^(2*FRAC_BITS).
  localparam logic signed [W_W-1:0] ESC_THR =
    {{(W_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  // Product chosen for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    logic     cap_rr;
    logic     cap_ii;
    logic     update;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escaped;
    logic overflow;
  } dp_stat_t;

endpackage

>>> hw/rtl/mandelbrot_escape_time.sv
// One point at a time: the next input beat comes as early as the result beat. Each step
// runs three products on the shared 30x30 multiplier, then the update. A run ends on
// escape, at the iteration limit, or when z leaves the multiplier range.
// Reset: asynchronous, active low; clears the sequencer and output valid, limit 255.
module mandelbrot_escape_time (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [mbe_pkg::IN_W-1:0] c_real_i,
  input  logic signed [mbe_pkg::IN_W-1:0] c_imag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mbe_pkg::CNT_W-1:0]       escape_step_o,
  output logic                            inside_res_o,
  input  logic                            cfg_we_i,
  input  logic [mbe_pkg::CNT_W-1:0]       cfg_wdata_i
);
  import mbe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: sequencing, step count and result register.
  mbe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .escape_step_o (escape_step_o),
    .inside_res_o  (inside_res_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  // Datapath: point and iterate registers, shared multiplier, escape test.
  mbe_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .c_real_i (c_real_i),
    .c_imag_i (c_imag_i),
    .stat_o   (stat)
  );

endmodule

>>> hw/rtl/mbe_dpath.sv
module mbe_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mbe_pkg::dp_cmd_t                cmd_i,
  input  logic signed [mbe_pkg::IN_W-1:0] c_real_i,
  input  logic signed [mbe_pkg::IN_W-1:0] c_imag_i,
  output mbe_pkg::dp_stat_t               stat_o
);
  import mbe_pkg::*;

  logic signed [IN_W-1:0]   c_r_q, c_i_q;
  logic signed [M_W-1:0]    z_r_q, z_i_q;
  logic signed [PROD_W-1:0] prod_q, rr_q, ii_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [M_W-1:0]    mul_a, mul_b;
  logic signed [W_W-1:0]    esc_sum, diff, re_sh, im_dbl, im_sh;
  logic signed [ZN_W-1:0]   zr_new, zi_new;
  logic signed [M_W-1:0]    zr_trunc, zi_trunc;
  logic                     fits_r, fits_i;

  // Operand selection for the single shared multiplier.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_RR: begin
        mul_a = z_r_q;
        mul_b = z_r_q;
      end
      MUL_II: begin
        mul_a = z_i_q;
        mul_b = z_i_q;
      end
      MUL_RI: begin
        mul_a = z_r_q;
        mul_b = z_i_q;
      end
      default: begin
        mul_a = z_r_q;
        mul_b = z_r_q;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Escape test of the current z: zr^2 held in rr_q, zi^2 just out of the multiplier.
  assign esc_sum = W_W'(rr_q) + W_W'(prod_q);

  // Next z: floor((zr^2 - zi^2) / 2^F) + cr and floor(2*zr*zi / 2^F) + ci.
  assign diff   = W_W'(rr_q) - W_W'(ii_q);
  assign re_sh  = diff >>> FRAC_BITS;
  assign im_dbl = signed'({prod_q, 1'b0});
  assign im_sh  = im_dbl >>> FRAC_BITS;
  assign zr_new = ZN_W'(re_sh) + ZN_W'(c_r_q);
  assign zi_new = ZN_W'(im_sh) + ZN_W'(c_i_q);

  // A new z that does not fit the multiplier width has |z| >= 4 and has escaped.
  assign zr_trunc = zr_new[M_W-1:0];
  assign zi_trunc = zi_new[M_W-1:0];
  assign fits_r   = (zr_new == ZN_W'(zr_trunc));
  assign fits_i   = (zi_new == ZN_W'(zi_trunc));

  assign stat_o.escaped  = (esc_sum > ESC_THR);
  assign stat_o.overflow = !(fits_r && fits_i);

  // Point, iterate and product registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      c_r_q <= c_real_i;
      c_i_q <= c_imag_i;
      z_r_q <= M_W'(c_real_i);
      z_i_q <= M_W'(c_imag_i);
    end else if (cmd_i.update) begin
      z_r_q <= zr_trunc;
      z_i_q <= zi_trunc;
    end
    if (cmd_i.cap_rr) begin
      rr_q <= prod_q;
    end
    if (cmd_i.cap_ii) begin
      ii_q <= prod_q;
    end
  end

  // A loaded point becomes the starting z.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (z_r_q == M_W'($past(c_real_i))) && (z_i_q == M_W'($past(c_imag_i))))
    else $error("z does not start at the loaded point");

endmodule

>>> hw/rtl/mbe_ctrl.sv
module mbe_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mbe_pkg::CNT_W-1:0]       escape_step_o,
  output logic                            inside_res_o,
  input  logic                            cfg_we_i,
  input  logic [mbe_pkg::CNT_W-1:0]       cfg_wdata_i,
  output mbe_pkg::dp_cmd_t                cmd_o,
  input  mbe_pkg::dp_stat_t               stat_i
);
  import mbe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RR,
    S_II,
    S_RI,
    S_UPD,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] limit_q;
  logic [CNT_W-1:0] res_step_q;
  logic             res_inside_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] out_step_q;
  logic             out_inside_q;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign escape_step_o = out_step_q;
  assign inside_res_o  = out_inside_q;

  // Datapath commands decoded from the state.
  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.cap_rr = (state_q == S_II);
    cmd_o.cap_ii = (state_q == S_RI);
    cmd_o.update = (state_q == S_UPD);
    unique case (state_q)
      S_II:    cmd_o.mul_sel = MUL_II;
      S_RI:    cmd_o.mul_sel = MUL_RI;
      default: cmd_o.mul_sel = MUL_RR;
    endcase
  end

  // Sequencer, step counter, limit register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      limit_q      <= LIMIT_RESET;
      res_step_q   <= '0;
      res_inside_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_step_q   <= '0;
      out_inside_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q   <= '0;
            state_q <= S_RR;
          end
        end
        S_RR: state_q <= S_II;
        S_II: state_q <= S_RI;
        S_RI: begin
          // The first round squares c, which is not tested.
          priority if (cnt_q != '0 && stat_i.escaped) begin
            res_step_q   <= cnt_q - CNT_W'(1);
            res_inside_q <= 1'b0;
            state_q      <= S_DONE;
          end else if (cnt_q == limit_q) begin
            res_step_q   <= '0;
            res_inside_q <= 1'b1;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (stat_i.overflow) begin
            res_step_q   <= cnt_q;
            res_inside_q <= 1'b0;
            state_q      <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= S_RR;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_step_q   <= res_step_q;
            out_inside_q <= res_inside_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // An accepted point starts a fresh first round.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RR) && (cnt_q == '0))
    else $error("accepted point did not start at step zero");

  // A finished result moves to a free output register at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not delivered to a free output register");

  // A point reported inside carries step zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (escape_step_o == '0))
    else $error("inside result with nonzero step");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mbe_pkg::*;

  // Cycles without any beat before the run is declared hung. The bound covers the slowest
  // point at a limit of 255, plus stalls on both sides and a limit write.
  localparam int HANG_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 40;

  // Iteration limit and number of random points for each phase.
  localparam int NUM_PHASES = 9;
  localparam int PH_LIMIT[NUM_PHASES] = '{255, 0, 1, 2, 7, 100, 254, 128, 255};
  localparam int PH_COUNT[NUM_PHASES] = '{120, 20, 50, 40, 60, 80, 60, 40, 130};

  // Directed points: zero, the corners of the 30-bit range, the exact |z| = 2
  // orbits at -2 and 1, the periodic orbits at +/-i, the cusp at 0.25 and just
  // past it, and points just outside the set.
  localparam int NUM_DIRECTED = 20;
  localparam int DIR_RE[NUM_DIRECTED] = '{
    0, -536870912, 536870911, -536870912, 536870911, -268435456, 268435456,
    134217728, 0, 0, 0, 33554432, 33554433, -268435457, -100663296, -1, 1, 0,
    -268435456, -536870912};
  localparam int DIR_IM[NUM_DIRECTED] = '{
    0, -536870912, 536870911, 536870911, -536870912, 0, 0,
    0, 134217728, -134217728, 268435456, 0, 0, 0, 13421773, -1, 0, -268435456,
    -268435456, 0};

  // Points on the edge of the set, where escapes take many steps.
  localparam int NUM_EDGE = 6;
  localparam int EDGE_RE[NUM_EDGE] = '{-100663296, 33554432, -167772160, -13421773,
                                       37580964, -237564969};
  localparam int EDGE_IM[NUM_EDGE] = '{13421773, 0, 0, 87241523, 71135396, 0};

  // |z|^2 > 4 at the scale of a full-width square.
  localparam logic signed [127:0] ESCAPE_BOUND = 128'sd4 <<< (2 * FRAC_BITS);

  typedef struct {
    logic [CNT_W-1:0] step;
    logic             in_set;
  } escape_t;

  // Predicts the escape time of each accepted point and checks results in order.
  class escape_scoreboard;
    logic [CNT_W-1:0] iter_limit;
    escape_t          expected_q[$];
    int               errors;
    int               n_checked;
    int               n_inside;
    int               deepest;

    function new();
      iter_limit = LIMIT_RESET;
      errors     = 0;
      n_checked  = 0;
      n_inside   = 0;
      deepest    = 0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] value);
      iter_limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Iterates z = z*z + c with full-width products and floored rescaling.
    function escape_t escape_time(logic signed [IN_W-1:0] cr_in,
                                  logic signed [IN_W-1:0] ci_in);
      logic signed [63:0]  cr;
      logic signed [63:0]  ci;
      logic signed [63:0]  zr;
      logic signed [63:0]  zi;
      logic signed [127:0] wr;
      logic signed [127:0] wi;
      logic signed [127:0] re_w;
      logic signed [127:0] im_w;
      logic signed [127:0] mag;
      escape_t             res;
      cr = cr_in;
      ci = ci_in;
      zr = cr;
      zi = ci;
      res.step   = '0;
      res.in_set = 1'b1;
      for (int i = 0; i < iter_limit; i++) begin
        wr   = zr;
        wi   = zi;
        re_w = (wr * wr - wi * wi) >>> FRAC_BITS;
        im_w = (wr * wi + wr * wi) >>> FRAC_BITS;
        zr   = re_w[63:0] + cr;
        zi   = im_w[63:0] + ci;
        wr   = zr;
        wi   = zi;
        mag  = wr * wr + wi * wi;
        if (mag > ESCAPE_BOUND) begin
          res.step   = CNT_W'(i);
          res.in_set = 1'b0;
          break;
        end
      end
      return res;
    endfunction

    function void note_point(logic signed [IN_W-1:0] cr, logic signed [IN_W-1:0] ci);
      expected_q.push_back(escape_time(cr, ci));
    endfunction

    function void check_result(logic [CNT_W-1:0] step, logic in_set);
      escape_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no point pending: escape_step %0d, inside_res %0b",
               step, in_set);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (step !== want.step) begin
        $error("escape_step: expected %0d, actual %0d", want.step, step);
        errors++;
      end
      if (in_set !== want.in_set) begin
        $error("inside_res: expected %0b, actual %0b", want.in_set, in_set);
        errors++;
      end
      if (want.in_set) begin
        n_inside++;
      end else if (int'(want.step) > deepest) begin
        deepest = int'(want.step);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [IN_W-1:0]  c_real = '0;
  logic signed [IN_W-1:0]  c_imag = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CNT_W-1:0]        escape_step;
  logic                    inside_res;
  logic                    cfg_we = 1'b0;
  logic [CNT_W-1:0]        cfg_wdata = '0;

  // Phases with no idling on either side.
  bit                      steady = 1'b0;
  int                      idle_cycles = 0;
  escape_scoreboard        sb;

  mandelbrot_escape_time dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .c_real_i     (c_real),
    .c_imag_i     (c_imag),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .escape_step_o(escape_step),
    .inside_res_o (inside_res),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sends one point after a random gap (none in steady phases) and waits for its beat.
  task automatic send_point(input logic signed [IN_W-1:0] cr,
                            input logic signed [IN_W-1:0] ci);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    c_real   <= cr;
    c_imag   <= ci;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_point(cr, ci);
  endtask

  // Draws a point: half within -2..2, some near the set's edge, some anywhere.
  task automatic pick_point(output logic signed [IN_W-1:0] cr,
                            output logic signed [IN_W-1:0] ci);
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      cr = IN_W'(int'($urandom_range(0, 536870912)) - 268435456);
      ci = IN_W'(int'($urandom_range(0, 536870912)) - 268435456);
    end else if (sel < 8) begin
      k  = $urandom_range(0, NUM_EDGE - 1);
      cr = IN_W'(EDGE_RE[k] + int'($urandom_range(0, 2097152)) - 1048576);
      ci = IN_W'(EDGE_IM[k] + int'($urandom_range(0, 2097152)) - 1048576);
    end else begin
      cr = IN_W'($urandom());
      ci = IN_W'($urandom());
    end
  endtask

  // Writes the iteration limit once every pending result has arrived.
  task automatic write_limit(input logic [CNT_W-1:0] value);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(value);
  endtask

  // Result side: random stalls between beats, none in steady phases.
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Check every result beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(escape_step, inside_res);
    end
  end

  // Hang detection: cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus: one iteration limit per phase, directed points in the first.
  initial begin
    logic signed [IN_W-1:0] cr;
    logic signed [IN_W-1:0] ci;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(CNT_W'(PH_LIMIT[p]));
      steady = (p == 3) || (p == 6);
      if (p == 0) begin
        for (int d = 0; d < NUM_DIRECTED; d++) begin
          send_point(IN_W'(DIR_RE[d]), IN_W'(DIR_IM[d]));
        end
      end
      for (int n = 0; n < PH_COUNT[p]; n++) begin
        pick_point(cr, ci);
        send_point(cr, ci);
      end
      in_valid <= 1'b0;
    end

    // Drain the remaining results, then let the block settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d points across %0d iteration limits from 0 to 255.",
             sb.n_checked, NUM_PHASES);
    $display("%0d points stayed inside; the deepest escape came at step %0d.",
             sb.n_inside, sb.deepest);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_dpath.sv
hw/rtl/mbe_ctrl.sv
hw/rtl/mandelbrot_escape_time.sv
dv/testbench.sv
